@@ src/pbpg_pkg.sv @@
// ----------------------------------------------------------------------------
// pbpg_pkg
// Shared widths, register map, reset values and control structs of the
// beat pulse generator.
// ----------------------------------------------------------------------------
package pbpg_pkg;

	localparam int COUNT_WIDTH  = 20;
	localparam int PHASE_WIDTH  = 32;
	localparam int AMP_WIDTH    = 15;
	localparam int BEAT_WIDTH   = 7;
	localparam int SAMPLE_WIDTH = 16;
	localparam int DATA_WIDTH   = 32;
	localparam int ADDR_WIDTH   = 5;
	localparam int IDX_WIDTH    = ADDR_WIDTH - 2;

	// envelope quotient bits: scale runs over 0..2^Q_BITS
	localparam int Q_BITS     = 10;
	localparam int QCNT_WIDTH = $clog2(Q_BITS);

	// divide by five through a reciprocal multiply
	localparam int DIV5_SHIFT = COUNT_WIDTH + 3;
	localparam logic [COUNT_WIDTH:0] DIV5_MUL =
		(COUNT_WIDTH + 1)'((64'd1 << DIV5_SHIFT) / 5 + 1);

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	localparam cnt_t MIN_RAMP = COUNT_WIDTH'(8);

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_PHASE_STEP  = 3'd0,
		REG_AMPLITUDE   = 3'd1,
		REG_TONE_LENGTH = 3'd2,
		REG_BEAT_PERIOD = 3'd3,
		REG_LEAD_IN     = 3'd4,
		REG_BEAT_COUNT  = 3'd5
	} reg_idx_t;

	localparam logic [PHASE_WIDTH-1:0] RST_PHASE_STEP = 32'd78741067;
	localparam logic [AMP_WIDTH-1:0]   RST_AMPLITUDE  = 15'd9000;
	localparam cnt_t                   RST_TONE       = COUNT_WIDTH'(3360);
	localparam cnt_t                   RST_PERIOD     = COUNT_WIDTH'(38400);
	localparam cnt_t                   RST_LEAD_IN    = COUNT_WIDTH'(28800);
	localparam logic [BEAT_WIDTH-1:0]  RST_BEATS      = 7'd12;

	typedef struct packed {
		logic [PHASE_WIDTH-1:0] phase_step;
		logic [AMP_WIDTH-1:0]   amplitude;
		cnt_t                   tone_length;
		cnt_t                   beat_period;
		cnt_t                   lead_in_length;
		logic [BEAT_WIDTH-1:0]  beat_count;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic step_stage;
		logic tri_load;
		logic prep;
		logic load_att;
		logic load_rel;
		logic div_step;
		logic mul;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic tone;
		logic need_att;
		logic need_rel;
		logic div_last;
	} stat_t;

endpackage

@@ src/pbpg_if.sv @@
// ----------------------------------------------------------------------------
// pbpg channel interfaces
// Valid/ready channels for sample ticks in and PCM frames out.
// ----------------------------------------------------------------------------
interface pbpg_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface pbpg_out_if;
	import pbpg_pkg::*;
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           in_tone;
	logic [BEAT_WIDTH-1:0]          beat_number;
	logic                           finished;

	modport source (output valid, output sample, output in_tone, output beat_number,
		output finished, input ready);
	modport sink (input valid, input sample, input in_tone, input beat_number,
		input finished, output ready);
endinterface

@@ src/pbpg_regs.sv @@
// ----------------------------------------------------------------------------
// pbpg_regs
// APB configuration registers of the beat pulse generator.
// ----------------------------------------------------------------------------
module pbpg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pbpg_pkg::ADDR_WIDTH-1:0]     paddr,
	input  logic [pbpg_pkg::DATA_WIDTH-1:0]     pwdata,
	output logic [pbpg_pkg::DATA_WIDTH-1:0]     prdata,
	output logic                                pready,
	output pbpg_pkg::cfg_t                      cfg
);
	import pbpg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step     <= RST_PHASE_STEP;
			cfg_q.amplitude      <= RST_AMPLITUDE;
			cfg_q.tone_length    <= RST_TONE;
			cfg_q.beat_period    <= RST_PERIOD;
			cfg_q.lead_in_length <= RST_LEAD_IN;
			cfg_q.beat_count     <= RST_BEATS;
		end else if (wr_en) begin
			case (idx)
				REG_PHASE_STEP:  cfg_q.phase_step     <= pwdata[PHASE_WIDTH-1:0];
				REG_AMPLITUDE:   cfg_q.amplitude      <= pwdata[AMP_WIDTH-1:0];
				REG_TONE_LENGTH: cfg_q.tone_length    <= pwdata[COUNT_WIDTH-1:0];
				REG_BEAT_PERIOD: cfg_q.beat_period    <= pwdata[COUNT_WIDTH-1:0];
				REG_LEAD_IN:     cfg_q.lead_in_length <= pwdata[COUNT_WIDTH-1:0];
				REG_BEAT_COUNT:  cfg_q.beat_count     <= pwdata[BEAT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PHASE_STEP:  prdata = DATA_WIDTH'(cfg_q.phase_step);
			REG_AMPLITUDE:   prdata = DATA_WIDTH'(cfg_q.amplitude);
			REG_TONE_LENGTH: prdata = DATA_WIDTH'(cfg_q.tone_length);
			REG_BEAT_PERIOD: prdata = DATA_WIDTH'(cfg_q.beat_period);
			REG_LEAD_IN:     prdata = DATA_WIDTH'(cfg_q.lead_in_length);
			REG_BEAT_COUNT:  prdata = DATA_WIDTH'(cfg_q.beat_count);
			default:         prdata = '0;
		endcase
	end

endmodule

@@ src/pbpg_dp.sv @@
// ----------------------------------------------------------------------------
// pbpg_dp
// Datapath: sequence state, phase accumulator, triangle and envelope math
// with a shared restoring divider, and the output register.
// ----------------------------------------------------------------------------
module pbpg_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pbpg_pkg::cfg_t                       cfg,
	input  pbpg_pkg::cmd_t                       cmd,
	input  logic                                 restart,
	output pbpg_pkg::stat_t                      st,
	output logic signed [pbpg_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                                 in_tone,
	output logic [pbpg_pkg::BEAT_WIDTH-1:0]      beat_number,
	output logic                                 finished
);
	import pbpg_pkg::*;

	typedef enum logic [2:0] {
		ST_LEAD,
		ST_TONE,
		ST_GAP,
		ST_TRAIL,
		ST_DONE
	} seq_stage_t;

	localparam logic [Q_BITS:0]       SCALE_ONE = (Q_BITS + 1)'(1 << Q_BITS);
	localparam logic [QCNT_WIDTH-1:0] Q_LAST    = QCNT_WIDTH'(Q_BITS - 1);
	localparam int                    PROD_W    = 2 * SAMPLE_WIDTH + 1;
	localparam int                    PROD2_W   = SAMPLE_WIDTH + Q_BITS + 2;

	// sequence state
	seq_stage_t             stage_q;
	logic [PHASE_WIDTH-1:0] phase_q;
	cnt_t                   fc_q;
	logic [BEAT_WIDTH-1:0]  bc_q;

	// arithmetic registers
	logic signed [PROD_W-1:0]       prod_q;
	cnt_t                           att_q;
	cnt_t                           rel_q;
	logic signed [SAMPLE_WIDTH-1:0] t_q;
	logic [Q_BITS:0]                scale_q;
	cnt_t                           drem_q;
	cnt_t                           dd_q;
	logic [Q_BITS-1:0]              quot_q;
	logic [QCNT_WIDTH-1:0]          dcnt_q;
	logic signed [PROD2_W-1:0]      prod2_q;

	// output register
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                           in_tone_q;
	logic [BEAT_WIDTH-1:0]          beat_q;
	logic                           finished_q;

	cnt_t                  eff_tone;
	cnt_t                  stage_len;
	logic [BEAT_WIDTH-1:0] bc_inc;

	always_comb begin
		if (cfg.beat_period == '0) begin
			eff_tone = '0;
		end else if (cfg.tone_length >= cfg.beat_period) begin
			eff_tone = cfg.beat_period - COUNT_WIDTH'(1);
		end else begin
			eff_tone = cfg.tone_length;
		end
	end

	always_comb begin
		case (stage_q)
			ST_LEAD:  stage_len = cfg.lead_in_length;
			ST_TONE:  stage_len = eff_tone;
			ST_GAP:   stage_len = cfg.beat_period - eff_tone;
			ST_TRAIL: stage_len = cfg.lead_in_length;
			default:  stage_len = '0;
		endcase
	end

	assign bc_inc = bc_q + BEAT_WIDTH'(1);

	// triangle wave from the top phase bits
	logic [SAMPLE_WIDTH-1:0]        ph_top;
	logic [SAMPLE_WIDTH-2:0]        tri_v;
	logic signed [SAMPLE_WIDTH:0]   tri_w;
	logic signed [SAMPLE_WIDTH-1:0] amp_s;
	logic signed [PROD_W-1:0]       tri_prod;

	assign ph_top   = phase_q[PHASE_WIDTH-1 -: SAMPLE_WIDTH];
	assign tri_v    = ph_top[SAMPLE_WIDTH-1] ? ~ph_top[SAMPLE_WIDTH-2:0]
		: ph_top[SAMPLE_WIDTH-2:0];
	assign tri_w    = ($signed({2'b00, tri_v}) - $signed((SAMPLE_WIDTH + 1)'(16384))) <<< 1;
	assign amp_s    = $signed({1'b0, cfg.amplitude});
	assign tri_prod = tri_w * amp_s;

	// attack and release lengths
	cnt_t                   att_div;
	logic [2*COUNT_WIDTH:0] rel_prod;
	logic [2*COUNT_WIDTH:0] rel_sh;
	cnt_t                   rel_div;
	cnt_t                   remn;

	assign att_div  = eff_tone >> 3;
	assign rel_prod = (2 * COUNT_WIDTH + 1)'(eff_tone) * (2 * COUNT_WIDTH + 1)'(DIV5_MUL);
	assign rel_sh   = rel_prod >> DIV5_SHIFT;
	assign rel_div  = rel_sh[COUNT_WIDTH-1:0];
	assign remn     = eff_tone - fc_q;

	// truncate toward zero on the amplitude scaling
	logic signed [PROD_W-1:0] t_adj;
	logic signed [PROD_W-1:0] t_full;

	assign t_adj  = prod_q + (prod_q[PROD_W-1] ? $signed(PROD_W'(32767)) : $signed(PROD_W'(0)));
	assign t_full = t_adj >>> 15;

	// restoring divider, one quotient bit a cycle
	logic [COUNT_WIDTH:0] dsh;
	logic [COUNT_WIDTH:0] dsub;
	logic                 dge;
	logic [Q_BITS-1:0]    q_next;

	assign dsh    = {drem_q, 1'b0};
	assign dge    = dsh >= {1'b0, dd_q};
	assign dsub   = dsh - {1'b0, dd_q};
	assign q_next = {quot_q[Q_BITS-2:0], dge};

	// envelope applied, again truncating toward zero
	logic signed [PROD2_W-1:0] s_adj;
	logic signed [PROD2_W-1:0] s_full;

	assign s_adj  = prod2_q + (prod2_q[PROD2_W-1] ? $signed(PROD2_W'(1023))
		: $signed(PROD2_W'(0)));
	assign s_full = s_adj >>> Q_BITS;

	assign st.skip     = (stage_q != ST_DONE) && (fc_q >= stage_len);
	assign st.tone     = stage_q == ST_TONE;
	assign st.need_att = fc_q < att_q;
	assign st.need_rel = remn < rel_q;
	assign st.div_last = dcnt_q == Q_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_LEAD;
			phase_q <= '0;
			fc_q    <= '0;
			bc_q    <= '0;
		end else if (cmd.start) begin
			if (restart) begin
				stage_q <= ST_LEAD;
				phase_q <= '0;
				fc_q    <= '0;
				bc_q    <= '0;
			end
		end else if (cmd.step_stage) begin
			fc_q <= '0;
			case (stage_q)
				ST_LEAD: stage_q <= (cfg.beat_count != '0) ? ST_TONE : ST_TRAIL;
				ST_TONE: stage_q <= ST_GAP;
				ST_GAP: begin
					bc_q    <= bc_inc;
					stage_q <= (bc_inc < cfg.beat_count) ? ST_TONE : ST_TRAIL;
				end
				default: stage_q <= ST_DONE;
			endcase
		end else if (cmd.finish) begin
			if (stage_q == ST_TONE) begin
				phase_q <= phase_q + cfg.phase_step;
			end
			if (stage_q != ST_DONE) begin
				fc_q <= fc_q + COUNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tri_load) begin
			prod_q <= tri_prod;
			att_q  <= (att_div < MIN_RAMP) ? MIN_RAMP : att_div;
			rel_q  <= (rel_div < MIN_RAMP) ? MIN_RAMP : rel_div;
		end
		if (cmd.prep) begin
			t_q <= t_full[SAMPLE_WIDTH-1:0];
		end
		if (cmd.load_att || cmd.load_rel) begin
			drem_q <= cmd.load_att ? fc_q : remn;
			dd_q   <= cmd.load_att ? att_q : rel_q;
			quot_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			drem_q <= dge ? dsub[COUNT_WIDTH-1:0] : dsh[COUNT_WIDTH-1:0];
			quot_q <= q_next;
			dcnt_q <= dcnt_q + QCNT_WIDTH'(1);
		end
		// envelope takes the smaller of attack and release ramps
		if (cmd.prep) begin
			scale_q <= SCALE_ONE;
		end else if (cmd.div_step && st.div_last && ({1'b0, q_next} < scale_q)) begin
			scale_q <= {1'b0, q_next};
		end
		if (cmd.mul) begin
			prod2_q <= t_q * $signed({1'b0, scale_q});
		end
		if (cmd.finish) begin
			sample_q   <= (stage_q == ST_TONE) ? s_full[SAMPLE_WIDTH-1:0] : '0;
			in_tone_q  <= stage_q == ST_TONE;
			beat_q     <= bc_q;
			finished_q <= stage_q == ST_DONE;
		end
	end

	assign sample      = sample_q;
	assign in_tone     = in_tone_q;
	assign beat_number = beat_q;
	assign finished    = finished_q;

	a_tone_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(st.tone && !st.skip) |-> (fc_q < eff_tone))
		else $error("tone frame outside the tone length");

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> (scale_q <= SCALE_ONE))
		else $error("envelope scale above unity");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && stage_q == ST_DONE) |=> (fc_q == $past(fc_q)))
		else $error("frame counter moved after the sequence finished");

endmodule

@@ src/pbpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbpg_ctrl
// Controller: accepts a tick, walks the stage transitions, sequences the
// envelope divisions and loads the output register.
// ----------------------------------------------------------------------------
module pbpg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  pbpg_pkg::stat_t  st,
	output pbpg_pkg::cmd_t   cmd
);
	import pbpg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SKIP,
		S_TRI,
		S_PREP,
		S_DIV_A,
		S_RCHK,
		S_DIV_R,
		S_MUL,
		S_FIN
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        fin_go;

	assign fin_go    = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SKIP;
				end
			end
			// one stage transition a cycle until the frame lands in a stage
			S_SKIP: begin
				if (st.skip) begin
					cmd.step_stage = 1'b1;
				end else begin
					state_d = st.tone ? S_TRI : S_FIN;
				end
			end
			S_TRI: begin
				cmd.tri_load = 1'b1;
				state_d      = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (st.need_att) begin
					cmd.load_att = 1'b1;
					state_d      = S_DIV_A;
				end else if (st.need_rel) begin
					cmd.load_rel = 1'b1;
					state_d      = S_DIV_R;
				end else begin
					state_d = S_MUL;
				end
			end
			S_DIV_A: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_RCHK;
				end
			end
			S_RCHK: begin
				if (st.need_rel) begin
					cmd.load_rel = 1'b1;
					state_d      = S_DIV_R;
				end else begin
					state_d = S_MUL;
				end
			end
			S_DIV_R: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (fin_go) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished frame not presented");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second tick taken while a frame is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("frame dropped while the receiver stalls");

endmodule

@@ src/pcm_beat_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// pcm_beat_pulse_generator
// Triangle tone burst sequencer: one PCM frame for every sample tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample tick per transaction; restart high begins the
//   sequence anew at the lead-in with the phase cleared. out_ch returns one
//   frame per tick: sample, in_tone, beat_number and finished.
//   The APB port holds the six registers at byte addresses 0, 4, .. 20.
//   Write them only while no tick is in work; the block does not check it.
// Frame sequence:
//   one tick at a time. A silent frame steps over each stage boundary it
//   crosses, empty stages (zero lengths) included, then loads the output
//   register. A tone frame also forms the triangle sample, runs the attack
//   division in the attack ramp and the release division in the release
//   ramp, and scales by the result; the restoring divider that forms the
//   ramp scale works one quotient bit a cycle.
// Reset and stall:
//   reset loads the register defaults and puts the sequence at the start of
//   the lead-in. A frame waits in the output register while out_ch stalls;
//   the next tick is still taken and is held back only when it is done and
//   the output register is still full.
// ----------------------------------------------------------------------------
module pcm_beat_pulse_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pbpg_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [pbpg_pkg::DATA_WIDTH-1:0] pwdata,
	output logic [pbpg_pkg::DATA_WIDTH-1:0] prdata,
	output logic                            pready,
	pbpg_in_if.sink                         in_ch,
	pbpg_out_if.source                      out_ch
);
	import pbpg_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t st;

	pbpg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pbpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	pbpg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.restart     (in_ch.restart),
		.st          (st),
		.sample      (out_ch.sample),
		.in_tone     (out_ch.in_tone),
		.beat_number (out_ch.beat_number),
		.finished    (out_ch.finished)
	);

endmodule
